### rtl/utx_pkg.sv
// utx_pkg: shared types and constants of the 8N1 UART transmitter.
// No dependencies; used by every other file of the block except utx_res_if.
`timescale 1ns / 1ps
package utx_pkg;

	localparam int DATA_BITS = 8;
	localparam int BYTE_W    = 8;
	localparam int TICK_W    = 16;
	localparam int POS_W     = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [TICK_W-1:0] TPB_RESET = TICK_W'(6076);

	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_LOAD = 1'b1;

	// classified request between front and back
	typedef struct packed {
		logic              load;
		logic [BYTE_W-1:0] data;
	} op_t;

endpackage

### rtl/utx_item_if.sv
// utx_item_if: input request channel (valid/ready, mode and byte).
// Depends on utx_pkg.
`timescale 1ns / 1ps
interface utx_item_if;
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic [utx_pkg::BYTE_W-1:0] data_byte;

	modport source (output valid, output mode, output data_byte, input ready);
	modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

### rtl/utx_res_if.sv
// utx_res_if: result channel (valid/ready, line level, busy, accepted).
// No dependencies.
`timescale 1ns / 1ps
interface utx_res_if;
	logic valid;
	logic ready;
	logic tx_level;
	logic busy_res;
	logic accepted;

	modport source (output valid, output tx_level, output busy_res, output accepted,
		input ready);
	modport sink   (input valid, input tx_level, input busy_res, input accepted,
		output ready);
endinterface

### rtl/utx_front.sv
// utx_front: accepts input requests and classifies them into load/tick ops.
// Depends on utx_pkg and utx_item_if.
`timescale 1ns / 1ps
module utx_front (
	input  logic             clk,
	input  logic             arst_n,
	utx_item_if.sink         item,
	output logic             op_valid,
	output utx_pkg::op_t     op,
	input  logic             op_ready
);

	logic         valid_s1;
	utx_pkg::op_t op_s1;
	logic         take;

	assign item.ready = !valid_s1 || op_ready;
	assign take       = item.valid && item.ready;
	assign op_valid   = valid_s1;
	assign op         = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (op_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1.load <= (item.mode == utx_pkg::MODE_LOAD);
			op_s1.data <= item.data_byte;
		end
	end

endmodule

### rtl/utx_queue.sv
// utx_queue: short FIFO of classified ops between front and back.
// Depends on utx_pkg.
`timescale 1ns / 1ps
module utx_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	input  utx_pkg::op_t push_op,
	output logic         push_ready,
	output logic         pop_valid,
	output utx_pkg::op_t pop_op,
	input  logic         pop_ready
);

	localparam int PTR_W = $clog2(utx_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(utx_pkg::QUEUE_DEPTH + 1);

	utx_pkg::op_t     mem_q [utx_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != CNT_W'(utx_pkg::QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_op     = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(utx_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(utx_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

### rtl/utx_back.sv
// utx_back: frame serializer (bit timer, shift data, line level) and result register.
// Depends on utx_pkg and utx_res_if.
`timescale 1ns / 1ps
module utx_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [utx_pkg::TICK_W-1:0]  cfg_data,
	input  logic                        op_valid,
	input  utx_pkg::op_t                op,
	output logic                        op_ready,
	utx_res_if.source                   result
);

	localparam logic [utx_pkg::POS_W-1:0] LAST_POS = utx_pkg::POS_W'(utx_pkg::DATA_BITS + 1);
	localparam logic [utx_pkg::POS_W-1:0] DATA_END = utx_pkg::POS_W'(utx_pkg::DATA_BITS);

	logic [utx_pkg::TICK_W-1:0] tpb_q;
	logic [utx_pkg::BYTE_W-1:0] shift_q;
	logic [utx_pkg::POS_W-1:0]  bit_pos_q;
	logic [utx_pkg::TICK_W-1:0] tick_cnt_q;
	logic                       sending_q;
	logic                       line_q;

	logic                       res_valid_q;
	logic                       res_level_q;
	logic                       res_busy_q;
	logic                       res_acc_q;

	logic                       step;
	logic [utx_pkg::TICK_W-1:0] limit;
	logic [utx_pkg::TICK_W-1:0] cnt_inc;
	logic [utx_pkg::POS_W-1:0]  pos_inc;
	logic [utx_pkg::POS_W-1:0]  idx;
	logic                       next_level;

	logic                       sending_d;
	logic                       line_d;
	logic [utx_pkg::POS_W-1:0]  bit_pos_d;
	logic [utx_pkg::TICK_W-1:0] tick_cnt_d;
	logic [utx_pkg::BYTE_W-1:0] shift_d;
	logic                       acc_d;

	assign op_ready = !res_valid_q || result.ready;
	assign step     = op_valid && op_ready;

	assign limit   = (tpb_q == '0) ? utx_pkg::TICK_W'(1) : tpb_q;
	assign cnt_inc = tick_cnt_q + utx_pkg::TICK_W'(1);
	assign pos_inc = bit_pos_q + utx_pkg::POS_W'(1);
	assign idx     = pos_inc - utx_pkg::POS_W'(1);

	// level of the bit that starts at pos_inc
	always_comb begin
		if (pos_inc == '0) begin
			next_level = 1'b0;
		end else if (pos_inc <= DATA_END) begin
			if (idx >= utx_pkg::POS_W'(utx_pkg::BYTE_W)) begin
				next_level = 1'b0;
			end else begin
				next_level = shift_q[idx[$clog2(utx_pkg::BYTE_W)-1:0]];
			end
		end else begin
			next_level = 1'b1;
		end
	end

	always_comb begin
		sending_d  = sending_q;
		line_d     = line_q;
		bit_pos_d  = bit_pos_q;
		tick_cnt_d = tick_cnt_q;
		shift_d    = shift_q;
		acc_d      = 1'b0;
		if (op.load) begin
			if (!sending_q) begin
				shift_d    = op.data;
				bit_pos_d  = '0;
				tick_cnt_d = '0;
				sending_d  = 1'b1;
				line_d     = 1'b0;
				acc_d      = 1'b1;
			end
		end else if (sending_q) begin
			tick_cnt_d = cnt_inc;
			if (cnt_inc >= limit) begin
				tick_cnt_d = '0;
				if (pos_inc > LAST_POS) begin
					sending_d = 1'b0;
					bit_pos_d = '0;
					line_d    = 1'b1;
				end else begin
					bit_pos_d = pos_inc;
					line_d    = next_level;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpb_q       <= utx_pkg::TPB_RESET;
			shift_q     <= '0;
			bit_pos_q   <= '0;
			tick_cnt_q  <= '0;
			sending_q   <= 1'b0;
			line_q      <= 1'b1;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tpb_q <= cfg_data;
			end
			if (step) begin
				shift_q     <= shift_d;
				bit_pos_q   <= bit_pos_d;
				tick_cnt_q  <= tick_cnt_d;
				sending_q   <= sending_d;
				line_q      <= line_d;
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_level_q <= line_d;
			res_busy_q  <= sending_d;
			res_acc_q   <= acc_d;
		end
	end

	assign result.valid    = res_valid_q;
	assign result.tx_level = res_level_q;
	assign result.busy_res = res_busy_q;
	assign result.accepted = res_acc_q;

	a_idle_high: assert property (@(posedge clk) disable iff (!arst_n)
		!sending_q |-> line_q)
		else $error("line not high while idle");

	a_idle_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!sending_q |-> (bit_pos_q == '0))
		else $error("bit position not cleared while idle");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_pos_q <= LAST_POS)
		else $error("bit position past stop bit");

	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		step && acc_d |=> sending_q && !line_q && (bit_pos_q == '0))
		else $error("taken load did not start a frame");

endmodule

### rtl/uart_tx_8n1_serializer_core.sv
// uart_tx_8n1_serializer_core: top level of the 8N1 UART transmitter.
// Depends on utx_pkg, utx_item_if, utx_res_if, utx_front, utx_queue, utx_back.
`timescale 1ns / 1ps
// Usage:
//  item channel (sink): each request is either a tick (mode 0) or a byte load
//  (mode 1, data_byte). A load is taken only while no frame is in flight;
//  otherwise it is refused (accepted = 0) and nothing changes.
//  result channel (source): one result per request with the line level,
//  busy flag and accepted flag after that request, in request order.
//  cfg_we/cfg_data: ticks per serial bit (0 acts as 1), written with no request
//  in flight; a write mid-frame applies at once to the current bit.
//  Frame: start bit low, 8 data bits LSB first, stop bit high, each held
//  ticks_per_bit tick requests; the line idles high.
//  Throughput: one request per cycle while results are taken. The result is
//  registered through the front register, the 2-entry queue and the back
//  result register; the serializer state updates in the same step.
//  Receiver stall: the result register holds, the queue fills and the front
//  keeps ready high until both the front register and the queue are full.
//  Reset: line high, idle, bit timer cleared, ticks_per_bit = 6076, all
//  channels empty.
module uart_tx_8n1_serializer_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [utx_pkg::TICK_W-1:0] cfg_data,
	utx_item_if.sink                   item,
	utx_res_if.source                  result
);

	logic         f_valid;
	utx_pkg::op_t f_op;
	logic         f_ready;
	logic         q_valid;
	utx_pkg::op_t q_op;
	logic         q_ready;

	utx_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.op_valid (f_valid),
		.op       (f_op),
		.op_ready (f_ready)
	);

	utx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_op    (f_op),
		.push_ready (f_ready),
		.pop_valid  (q_valid),
		.pop_op     (q_op),
		.pop_ready  (q_ready)
	);

	utx_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.op_valid (q_valid),
		.op       (q_op),
		.op_ready (q_ready),
		.result   (result)
	);

endmodule

### dv/testbench.sv
// testbench: checks the 8N1 UART transmitter core against an in-bench serializer
// model, one predicted line/busy/accepted result per request, under random stalls.
// Depends on utx_pkg, utx_item_if, utx_res_if and uart_tx_8n1_serializer_core.
`timescale 1ns / 1ps
module testbench;
	import utx_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS    = 30;

	typedef struct packed {
		logic tx_level;
		logic busy;
		logic accepted;
	} line_obs_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [TICK_W-1:0] cfg_data;

	utx_item_if item_ch ();
	utx_res_if  res_ch ();

	uart_tx_8n1_serializer_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.item     (item_ch),
		.result   (res_ch)
	);

	// serializer model state
	logic [TICK_W-1:0] tpb_q;
	logic [BYTE_W-1:0] shreg;
	logic [POS_W-1:0]  bit_pos;
	logic [TICK_W-1:0] bit_ticks;
	logic              frame_active;
	logic              line_q;

	line_obs_t pending_obs[$];

	int send_idle_pct;
	int recv_idle_pct;
	int err_count;
	int req_count;
	int frames_started;
	int loads_refused;
	int results_checked;
	int quiet_cycles;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic line_obs_t step_serializer(input logic m, input logic [BYTE_W-1:0] b);
		line_obs_t o;
		logic [TICK_W-1:0] lim;
		int idx;
		o.accepted = 1'b0;
		if (m == MODE_LOAD) begin
			if (!frame_active) begin
				shreg        = b;
				bit_pos      = '0;
				bit_ticks    = '0;
				frame_active = 1'b1;
				line_q       = 1'b0;
				o.accepted   = 1'b1;
			end
		end else if (frame_active) begin
			lim = (tpb_q == '0) ? TICK_W'(1) : tpb_q;
			bit_ticks = bit_ticks + TICK_W'(1);
			if (bit_ticks >= lim) begin
				bit_ticks = '0;
				bit_pos   = bit_pos + POS_W'(1);
				if (int'(bit_pos) > DATA_BITS + 1) begin
					frame_active = 1'b0;
					bit_pos      = '0;
					line_q       = 1'b1;
				end else if (int'(bit_pos) <= DATA_BITS) begin
					idx    = int'(bit_pos) - 1;
					line_q = (idx < BYTE_W) ? shreg[idx] : 1'b0;
				end else begin
					line_q = 1'b1;
				end
			end
		end
		o.tx_level = line_q;
		o.busy     = frame_active;
		return o;
	endfunction

	function automatic int bit_span();
		return (tpb_q == '0) ? 1 : int'(tpb_q);
	endfunction

	// one request; returns at the edge where it is taken, valid left high
	task automatic send_req(input logic m, input logic [BYTE_W-1:0] b);
		line_obs_t o;
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.mode      <= m;
		item_ch.data_byte <= b;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		o = step_serializer(m, b);
		pending_obs.push_back(o);
		req_count++;
		if (m == MODE_LOAD) begin
			if (o.accepted)
				frames_started++;
			else
				loads_refused++;
		end
	endtask

	task automatic drain_results();
		item_ch.valid <= 1'b0;
		while (pending_obs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic finish_frame();
		while (frame_active)
			send_req(MODE_TICK, BYTE_W'($urandom));
	endtask

	// register write with no request in flight; a frame may still be running
	task automatic set_tpb(input logic [TICK_W-1:0] v);
		drain_results();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		tpb_q = v;
	endtask

	task automatic write_tpb(input logic [TICK_W-1:0] v);
		finish_frame();
		set_tpb(v);
	endtask

	task automatic run_frames(input int n_items);
		int sent;
		int span;
		int k;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 8) begin
				send_req(logic'($urandom_range(1)), BYTE_W'($urandom));
				sent++;
			end else begin
				send_req(MODE_LOAD, BYTE_W'($urandom));
				sent++;
				span = 10 * bit_span();
				if ($urandom_range(99) < 20)
					span = span - $urandom_range(bit_span());
				else
					span = span + $urandom_range(2);
				for (k = 0; k < span; k++) begin
					if ($urandom_range(99) < 5)
						send_req(MODE_LOAD, BYTE_W'($urandom));
					else
						send_req(MODE_TICK, BYTE_W'($urandom));
					sent++;
				end
			end
		end
	endtask

	// default bit time out of reset, then a shorter bit time written mid-frame
	task automatic test_reset_rate();
		int k;
		send_req(MODE_TICK, 8'hFF);
		send_req(MODE_TICK, 8'h00);
		send_req(MODE_LOAD, 8'hC3);
		send_req(MODE_LOAD, 8'h3C);
		for (k = 0; k < 40; k++)
			send_req(MODE_TICK, BYTE_W'($urandom));
		// start bit has already lasted longer than the new bit time
		set_tpb(TICK_W'(3));
		finish_frame();
		send_req(MODE_TICK, 8'h00);
	endtask

	task automatic test_directed_frames();
		int k;
		write_tpb(TICK_W'(1));
		send_req(MODE_LOAD, 8'h00);
		for (k = 0; k < 10; k++)
			send_req(MODE_TICK, 8'hFF);
		send_req(MODE_LOAD, 8'hFF);
		send_req(MODE_LOAD, 8'h00);
		for (k = 0; k < 9; k++)
			send_req(MODE_TICK, 8'h00);
		send_req(MODE_LOAD, 8'hAA);
		send_req(MODE_TICK, 8'h55);
		send_req(MODE_LOAD, 8'h5A);
		write_tpb(TICK_W'(0));
		send_req(MODE_LOAD, 8'h81);
		finish_frame();
	endtask

	task automatic test_random_traffic();
		int p;
		int s;
		logic [TICK_W-1:0] settings [5];
		for (p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_idle_pct = 29;
					recv_idle_pct = 46;
				end
				1: begin
					send_idle_pct = 46;
					recv_idle_pct = 29;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			settings = '{TICK_W'(1), TICK_W'(2), TICK_W'(0), TICK_W'(3),
				TICK_W'($urandom_range(4, 12))};
			for (s = 0; s < 5; s++) begin
				write_tpb(settings[s]);
				run_frames(95);
				if (s == 2)
					drain_results();
			end
		end
	endtask

	// widest bit time: frame is far too long to finish, check its opening stretch
	task automatic test_max_tpb();
		int k;
		write_tpb(16'hFFFF);
		send_req(MODE_LOAD, 8'h96);
		for (k = 0; k < 200; k++) begin
			if ($urandom_range(99) < 10)
				send_req(MODE_LOAD, BYTE_W'($urandom));
			else
				send_req(MODE_TICK, BYTE_W'($urandom));
		end
	endtask

	always @(posedge clk)
		res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		line_obs_t e;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_obs.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("%0t unexpected result: expected none actual %b%b%b", $time,
						res_ch.tx_level, res_ch.busy_res, res_ch.accepted);
			end else begin
				e = pending_obs.pop_front();
				results_checked++;
				if ({res_ch.tx_level, res_ch.busy_res, res_ch.accepted} !== e) begin
					err_count++;
					if (err_count <= MAX_REPORTS) begin
						if (res_ch.tx_level !== e.tx_level)
							$display("%0t tx_level mismatch: expected %b actual %b", $time,
								e.tx_level, res_ch.tx_level);
						if (res_ch.busy_res !== e.busy)
							$display("%0t busy_res mismatch: expected %b actual %b", $time,
								e.busy, res_ch.busy_res);
						if (res_ch.accepted !== e.accepted)
							$display("%0t accepted mismatch: expected %b actual %b", $time,
								e.accepted, res_ch.accepted);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("%0t watchdog: no request or result moved for %0d cycles", $time,
					WATCHDOG_LIMIT);
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	initial begin
		item_ch.valid     <= 1'b0;
		item_ch.mode      <= MODE_TICK;
		item_ch.data_byte <= '0;
		cfg_we            <= 1'b0;
		cfg_data          <= '0;
		arst_n            <= 1'b0;
		tpb_q           = TPB_RESET;
		shreg           = '0;
		bit_pos         = '0;
		bit_ticks       = '0;
		frame_active    = 1'b0;
		line_q          = 1'b1;
		send_idle_pct   = 0;
		recv_idle_pct   = 0;
		err_count       = 0;
		req_count       = 0;
		frames_started  = 0;
		loads_refused   = 0;
		results_checked = 0;
		quiet_cycles    = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_rate();
		test_directed_frames();
		test_random_traffic();
		test_max_tpb();

		drain_results();
		repeat (16) @(posedge clk);
		$display("covered %0d requests, %0d frames started, %0d loads refused while busy",
			req_count, frames_started, loads_refused);
		$display("bit times 0..65535, reset value and a mid-frame change, %0d results checked, %0d errors",
			results_checked, err_count);
		if (err_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

### sim.f
rtl/utx_pkg.sv
rtl/utx_item_if.sv
rtl/utx_res_if.sv
rtl/utx_front.sv
rtl/utx_queue.sv
rtl/utx_back.sv
rtl/uart_tx_8n1_serializer_core.sv
dv/testbench.sv
